// File: design/cale_pkg.sv
`timescale 1ns / 1ps

package cale_pkg;

    // command codes carried on func
    localparam logic [2:0] FUNC_INSERT = 3'd0;
    localparam logic [2:0] FUNC_REMOVE = 3'd1;
    localparam logic [2:0] FUNC_START  = 3'd2;
    localparam logic [2:0] FUNC_END    = 3'd3;
    localparam logic [2:0] FUNC_PREV   = 3'd4;
    localparam logic [2:0] FUNC_NEXT   = 3'd5;
    localparam logic [2:0] FUNC_MOVE   = 3'd6;
    localparam logic [2:0] FUNC_GET    = 3'd7;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef logic [3:0] t_upc;

    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_CHKFULL,
        UOP_SHUP,
        UOP_WRITEITEM,
        UOP_CHKCUR,
        UOP_CAPT,
        UOP_SHDN,
        UOP_DEC,
        UOP_START,
        UOP_END,
        UOP_PREV,
        UOP_NEXT,
        UOP_MOVE,
        UOP_FIN
    } t_uop;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_FULL,
        COND_NOCUR,
        COND_UP_MORE,
        COND_DN_MORE
    } t_cond;

    typedef struct packed {
        t_uop  op;
        t_cond cond;
        t_upc  target;
    } t_uword;

    // microprogram addresses, some of them entry points
    localparam t_upc UPC_INS0  = 4'd0;
    localparam t_upc UPC_INS1  = 4'd1;
    localparam t_upc UPC_INS2  = 4'd2;
    localparam t_upc UPC_REM0  = 4'd3;
    localparam t_upc UPC_REM1  = 4'd4;
    localparam t_upc UPC_REM2  = 4'd5;
    localparam t_upc UPC_REM3  = 4'd6;
    localparam t_upc UPC_GET0  = 4'd7;
    localparam t_upc UPC_GET1  = 4'd8;
    localparam t_upc UPC_START = 4'd9;
    localparam t_upc UPC_END   = 4'd10;
    localparam t_upc UPC_PREV  = 4'd11;
    localparam t_upc UPC_NEXT  = 4'd12;
    localparam t_upc UPC_MOVE  = 4'd13;
    localparam t_upc UPC_FIN   = 4'd14;

    function automatic t_uword ucode_rom(input t_upc a);
        t_uword w;
        case (a)
            UPC_INS0:  w = '{UOP_CHKFULL,   COND_FULL,    UPC_FIN};
            UPC_INS1:  w = '{UOP_SHUP,      COND_UP_MORE, UPC_INS1};
            UPC_INS2:  w = '{UOP_WRITEITEM, COND_ALWAYS,  UPC_FIN};
            UPC_REM0:  w = '{UOP_CHKCUR,    COND_NOCUR,   UPC_FIN};
            UPC_REM1:  w = '{UOP_CAPT,      COND_NEXT,    UPC_FIN};
            UPC_REM2:  w = '{UOP_SHDN,      COND_DN_MORE, UPC_REM2};
            UPC_REM3:  w = '{UOP_DEC,       COND_ALWAYS,  UPC_FIN};
            UPC_GET0:  w = '{UOP_CHKCUR,    COND_NOCUR,   UPC_FIN};
            UPC_GET1:  w = '{UOP_CAPT,      COND_ALWAYS,  UPC_FIN};
            UPC_START: w = '{UOP_START,     COND_ALWAYS,  UPC_FIN};
            UPC_END:   w = '{UOP_END,       COND_ALWAYS,  UPC_FIN};
            UPC_PREV:  w = '{UOP_PREV,      COND_ALWAYS,  UPC_FIN};
            UPC_NEXT:  w = '{UOP_NEXT,      COND_ALWAYS,  UPC_FIN};
            UPC_MOVE:  w = '{UOP_MOVE,      COND_ALWAYS,  UPC_FIN};
            UPC_FIN:   w = '{UOP_FIN,       COND_ALWAYS,  UPC_FIN};
            default:   w = '{UOP_NOP,       COND_ALWAYS,  UPC_FIN};
        endcase
        return w;
    endfunction

    function automatic t_upc dispatch(input logic [2:0] f);
        t_upc a;
        case (f)
            FUNC_INSERT: a = UPC_INS0;
            FUNC_REMOVE: a = UPC_REM0;
            FUNC_START:  a = UPC_START;
            FUNC_END:    a = UPC_END;
            FUNC_PREV:   a = UPC_PREV;
            FUNC_NEXT:   a = UPC_NEXT;
            FUNC_MOVE:   a = UPC_MOVE;
            FUNC_GET:    a = UPC_GET0;
            default:     a = UPC_FIN;
        endcase
        return a;
    endfunction

endpackage

// File: design/cursor_array_list_engine.sv
`timescale 1ns / 1ps

// Array list with a cursor, held in an on-chip store of CAPACITY entries.
// Command channel: drive i_func, i_item_value and i_target_pos with start;
// the command transfers at the clock edge where start is high and busy low.
// busy stays high until the result has been produced.
// Result channel: o_result_strobe is high for exactly one cycle with the
// removed/read value, length, cursor and status; the receiver cannot stall,
// so the result must be taken in that cycle. busy drops in that same cycle,
// so the next command may transfer while the result is shown.
// Insert and remove move one entry per cycle through the single write port
// and registered read port of the store; the read of one entry overlaps the
// write of the one before.
// Control is a microprogram in a small ROM: func selects an entry point,
// each step drives one datapath operation and may jump on a condition.
// Reset (synchronous, active low) empties the list and parks the cursor at
// 0; the store itself is not cleared, entries are only used once written.
module cursor_array_list_engine
    import cale_pkg::*;
#(
    parameter int CAPACITY   = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [2:0]                         i_func,
    input  logic signed [DATA_WIDTH-1:0]       i_item_value,
    input  logic [$clog2(CAPACITY+1)-1:0]      i_target_pos,
    output logic                               o_result_strobe,
    output logic signed [DATA_WIDTH-1:0]       o_read_value,
    output logic                               o_value_valid,
    output logic [$clog2(CAPACITY+1)-1:0]      o_list_length,
    output logic [$clog2(CAPACITY+1)-1:0]      o_cursor_pos,
    output logic [1:0]                         o_status
);

    localparam int CW = $clog2(CAPACITY + 1);   // counts 0..CAPACITY
    localparam int AW = $clog2(CAPACITY);       // store address
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // the store
    logic [DATA_WIDTH-1:0] mem [CAPACITY];
    logic [DATA_WIDTH-1:0] r_rdata;
    logic                  mem_we, mem_re;
    logic [AW-1:0]         mem_wa, mem_ra;
    logic [DATA_WIDTH-1:0] mem_wd;

    // sequencer and list state
    logic                  r_busy,   n_busy;
    t_upc                  r_upc,    n_upc;
    logic [CW-1:0]         r_count,  n_count;
    logic [CW-1:0]         r_cursor, n_cursor;
    logic [CW-1:0]         r_idx,    n_idx;
    logic [AW-1:0]         r_wa,     n_wa;
    logic                  r_pend,   n_pend;

    // latched command and working result
    logic [DATA_WIDTH-1:0] r_item,   n_item;
    logic [CW-1:0]         r_target, n_target;
    logic [DATA_WIDTH-1:0] r_value,  n_value;
    logic                  r_valid,  n_valid;
    logic [1:0]            r_status, n_status;

    // result registers
    logic                  r_strobe,      n_strobe;
    logic [DATA_WIDTH-1:0] r_res_value,   n_res_value;
    logic                  r_res_valid,   n_res_valid;
    logic [CW-1:0]         r_res_len,     n_res_len;
    logic [CW-1:0]         r_res_cur,     n_res_cur;
    logic [1:0]            r_res_status,  n_res_status;

    t_uword                uw;
    logic                  cond_true;

    assign uw = ucode_rom(r_upc);

    always_comb begin
        case (uw.cond)
            COND_NEXT:    cond_true = 1'b0;
            COND_ALWAYS:  cond_true = 1'b1;
            COND_FULL:    cond_true = (r_count == CAP_C);
            COND_NOCUR:   cond_true = (r_cursor >= r_count);
            COND_UP_MORE: cond_true = (r_idx > r_cursor);
            COND_DN_MORE: cond_true = (r_idx < r_count);
            default:      cond_true = 1'b0;
        endcase
    end

    always_comb begin
        n_busy       = r_busy;
        n_upc        = r_upc;
        n_count      = r_count;
        n_cursor     = r_cursor;
        n_idx        = r_idx;
        n_wa         = r_wa;
        n_pend       = r_pend;
        n_item       = r_item;
        n_target     = r_target;
        n_value      = r_value;
        n_valid      = r_valid;
        n_status     = r_status;
        n_strobe     = 1'b0;
        n_res_value  = r_res_value;
        n_res_valid  = r_res_valid;
        n_res_len    = r_res_len;
        n_res_cur    = r_res_cur;
        n_res_status = r_res_status;
        mem_we       = 1'b0;
        mem_wa       = r_wa;
        mem_wd       = r_rdata;
        mem_re       = 1'b0;
        mem_ra       = r_cursor[AW-1:0];

        if (!r_busy) begin
            if (start) begin
                n_busy   = 1'b1;
                n_upc    = dispatch(i_func);
                n_item   = i_item_value;
                n_target = i_target_pos;
                n_value  = '0;
                n_valid  = 1'b0;
                n_status = ST_OK;
            end
        end else begin
            n_upc = cond_true ? uw.target : r_upc + 4'd1;
            case (uw.op)
                UOP_CHKFULL: begin
                    if (r_count == CAP_C) n_status = ST_FULL;
                    n_idx  = r_count;
                    n_pend = 1'b0;
                end
                UOP_SHUP: begin
                    // write back the entry read last cycle one place higher
                    mem_we = r_pend;
                    if (r_idx > r_cursor) begin
                        mem_re = 1'b1;
                        mem_ra = AW'(r_idx - CW'(1));
                        n_wa   = r_idx[AW-1:0];
                        n_idx  = r_idx - CW'(1);
                        n_pend = 1'b1;
                    end else begin
                        n_pend = 1'b0;
                    end
                end
                UOP_WRITEITEM: begin
                    mem_we  = 1'b1;
                    mem_wa  = r_cursor[AW-1:0];
                    mem_wd  = r_item;
                    n_count = r_count + CW'(1);
                end
                UOP_CHKCUR: begin
                    if (r_cursor >= r_count) n_status = ST_EMPTY;
                    mem_re = 1'b1;
                    mem_ra = r_cursor[AW-1:0];
                    n_idx  = r_cursor + CW'(1);
                    n_pend = 1'b0;
                end
                UOP_CAPT: begin
                    n_value = r_rdata;
                    n_valid = 1'b1;
                end
                UOP_SHDN: begin
                    // write back the entry read last cycle one place lower
                    mem_we = r_pend;
                    if (r_idx < r_count) begin
                        mem_re = 1'b1;
                        mem_ra = r_idx[AW-1:0];
                        n_wa   = AW'(r_idx - CW'(1));
                        n_idx  = r_idx + CW'(1);
                        n_pend = 1'b1;
                    end else begin
                        n_pend = 1'b0;
                    end
                end
                UOP_DEC: begin
                    n_count = r_count - CW'(1);
                end
                UOP_START: begin
                    n_cursor = '0;
                end
                UOP_END: begin
                    n_cursor = (r_count != '0) ? r_count - CW'(1) : '0;
                end
                UOP_PREV: begin
                    if (r_cursor != '0) n_cursor = r_cursor - CW'(1);
                end
                UOP_NEXT: begin
                    if (r_cursor < r_count) n_cursor = r_cursor + CW'(1);
                end
                UOP_MOVE: begin
                    if (r_target > r_count) n_status = ST_RANGE;
                    else n_cursor = r_target;
                end
                UOP_FIN: begin
                    n_busy       = 1'b0;
                    n_strobe     = 1'b1;
                    n_res_value  = r_value;
                    n_res_valid  = r_valid;
                    n_res_len    = r_count;
                    n_res_cur    = r_cursor;
                    n_res_status = r_status;
                end
                default: begin
                    n_busy = r_busy;
                end
            endcase
        end
    end

    // store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        if (mem_re) r_rdata <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_upc    <= UPC_FIN;
            r_count  <= '0;
            r_cursor <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_upc    <= n_upc;
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
        end
        r_idx        <= n_idx;
        r_wa         <= n_wa;
        r_item       <= n_item;
        r_target     <= n_target;
        r_value      <= n_value;
        r_valid      <= n_valid;
        r_status     <= n_status;
        r_res_value  <= n_res_value;
        r_res_valid  <= n_res_valid;
        r_res_len    <= n_res_len;
        r_res_cur    <= n_res_cur;
        r_res_status <= n_res_status;
    end

    assign busy            = r_busy;
    assign o_result_strobe = r_strobe;
    assign o_read_value    = r_res_value;
    assign o_value_valid   = r_res_valid;
    assign o_list_length   = r_res_len;
    assign o_cursor_pos    = r_res_cur;
    assign o_status        = r_res_status;

    a_cursor_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= r_count)
        else $error("cursor beyond list length");

    a_count_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("list length beyond capacity");

    a_strobe_ends_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> (!busy && $past(busy)))
        else $error("result strobe without a command in flight");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !o_result_strobe)
        else $error("result strobe held for more than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_result_strobe))
        else $error("transferred command did not raise busy");

endmodule
